// ===== hw/rtl/ts_ss_pkg.sv =====
// ----------------------------------------------------------------------------
// ts_ss_pkg
// Shared types and constants for the transport stream sync search unit.
// ----------------------------------------------------------------------------
package ts_ss_pkg;

    localparam int RES_BITS    = 8;
    localparam int CONF_BITS   = 13;
    localparam int STATUS_BITS = 3;
    localparam int MIN_LENGTH  = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]           SYNC_BYTE = 8'h47;
    localparam logic [CONF_BITS-1:0] RUN_MAX   = 13'h1FFF;
    localparam logic [7:0]           MIN_PACKETS_RST = 8'd3;

    localparam logic [STATUS_BITS-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NONE     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FEW      = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_SHORT    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 3'd4;

    // classification of one byte, handed from front to back
    typedef struct packed {
        logic                sync;
        logic                fresh;
        logic                last;
        logic                skip;
        logic [RES_BITS-1:0] res;
    } t_item_ctl;

endpackage

// ===== hw/rtl/ts_ss_front.sv =====
// ----------------------------------------------------------------------------
// ts_ss_front
// Accepts bytes, tracks position, residue and overflow, classifies each item.
// ----------------------------------------------------------------------------
module ts_ss_front #(
    parameter int PACKET_BYTES  = 188,
    parameter int POSITION_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_last,
    input  logic                     i_full,
    output logic                     o_push,
    output ts_ss_pkg::t_item_ctl     o_ctl,
    output logic [POSITION_BITS-1:0] o_pos
);
    import ts_ss_pkg::*;

    localparam int CNT_BITS = POSITION_BITS + 1;

    logic [CNT_BITS-1:0] r_cnt;
    logic [RES_BITS-1:0] r_res;
    logic                r_ovf;
    logic                skip;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // top bit of the count set means the buffer already holds 2^POSITION_BITS bytes
    assign skip = r_ovf || r_cnt[CNT_BITS-1];

    always_comb begin
        o_ctl.sync  = (i_data_byte == SYNC_BYTE);
        o_ctl.fresh = (r_cnt < CNT_BITS'(PACKET_BYTES));
        o_ctl.last  = i_last;
        o_ctl.skip  = skip;
        o_ctl.res   = r_res;
        o_pos       = r_cnt[POSITION_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_res <= '0;
            r_ovf <= 1'b0;
        end else if (o_push) begin
            if (i_last) begin
                r_cnt <= '0;
                r_res <= '0;
                r_ovf <= 1'b0;
            end else if (skip) begin
                r_ovf <= 1'b1;
            end else begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                r_res <= (r_res == RES_BITS'(PACKET_BYTES - 1)) ? '0 : r_res + RES_BITS'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/ts_ss_queue.sv =====
// ----------------------------------------------------------------------------
// ts_ss_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module ts_ss_queue #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import ts_ss_pkg::*;

    logic [WIDTH-1:0]     r_slot [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;

    assign o_full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_BITS+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_BITS+1)'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/ts_ss_back.sv =====
// ----------------------------------------------------------------------------
// ts_ss_back
// Updates the per-residue run tables and, after the last byte, scans them
// for the earliest run start that fits a whole packet; a short or overflowed buffer skips the scan.
// ----------------------------------------------------------------------------
module ts_ss_back #(
    parameter int PACKET_BYTES  = 188,
    parameter int POSITION_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [7:0]                          i_cfg_data,
    input  logic                                i_empty,
    input  ts_ss_pkg::t_item_ctl                i_ctl,
    input  logic [POSITION_BITS-1:0]            i_pos,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ts_ss_pkg::STATUS_BITS-1:0]   o_status,
    output logic [POSITION_BITS-1:0]            o_position,
    output logic [ts_ss_pkg::CONF_BITS-1:0]     o_confirmations
);
    import ts_ss_pkg::*;

    localparam int EW  = POSITION_BITS + CONF_BITS;
    localparam int LW  = POSITION_BITS + 1;

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [EW-1:0]            r_mem [PACKET_BYTES];
    logic [EW-1:0]            r_rd;
    logic [RES_BITS-1:0]      rd_addr;
    logic [POSITION_BITS-1:0] rd_start;
    logic [CONF_BITS-1:0]     rd_len;

    logic [1:0]               r_state;
    logic                     r_a_v;
    t_item_ctl                r_a_ctl;
    logic [POSITION_BITS-1:0] r_a_pos;

    logic                     wr_en;
    logic [POSITION_BITS-1:0] wr_start;
    logic [CONF_BITS-1:0]     wr_len;

    logic [7:0]               r_min_packets;
    logic [LW-1:0]            r_len;
    logic [RES_BITS-1:0]      r_n;
    logic [RES_BITS-1:0]      r_idx;
    logic                     r_cmp_v;
    logic                     r_have;
    logic [POSITION_BITS-1:0] r_best;
    logic [CONF_BITS-1:0]     r_best_len;
    logic [STATUS_BITS-1:0]   r_pre_status;
    logic                     cmp_hit;
    logic [LW-1:0]            a_len;
    logic [CONF_BITS-1:0]     conf;

    logic                     r_out_v;
    logic [STATUS_BITS-1:0]   r_out_status;
    logic [POSITION_BITS-1:0] r_out_pos;
    logic [CONF_BITS-1:0]     r_out_conf;

    assign rd_start = r_rd[EW-1:CONF_BITS];
    assign rd_len   = r_rd[CONF_BITS-1:0];

    // no pop once a last item is in stage A: the scan must see its write
    assign o_pop   = (r_state == S_RUN) && !i_empty && !(r_a_v && r_a_ctl.last);
    assign rd_addr = (r_state == S_SCAN) ? r_idx : i_ctl.res;

    always_comb begin
        wr_en    = (r_state == S_RUN) && r_a_v && !r_a_ctl.skip;
        wr_start = rd_start;
        wr_len   = rd_len;
        if (r_a_ctl.sync) begin
            if (r_a_ctl.fresh || rd_len == '0) begin
                wr_start = r_a_pos;
                wr_len   = CONF_BITS'(1);
            end else if (rd_len != RUN_MAX) begin
                wr_len   = rd_len + CONF_BITS'(1);
            end
        end else begin
            wr_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_a_ctl.res] <= {wr_start, wr_len};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign a_len   = {1'b0, r_a_pos} + LW'(1);
    assign cmp_hit = r_cmp_v && (rd_len != '0)
                     && (({1'b0, rd_start} + LW'(PACKET_BYTES)) <= r_len)
                     && (!r_have || rd_start < r_best);
    assign conf    = r_best_len - CONF_BITS'(1);

    always_ff @(posedge i_clk) begin
        r_a_ctl <= i_ctl;
        r_a_pos <= i_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_RUN;
            r_a_v         <= 1'b0;
            r_cmp_v       <= 1'b0;
            r_have        <= 1'b0;
            r_out_v       <= 1'b0;
            r_min_packets <= MIN_PACKETS_RST;
        end else begin
            if (i_cfg_we) begin
                r_min_packets <= i_cfg_data;
            end
            if (r_state == S_DONE && (!r_out_v || !i_stall)) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end
            r_a_v <= o_pop;
            case (r_state)
                S_RUN: begin
                    if (r_a_v && r_a_ctl.last) begin
                        r_have  <= 1'b0;
                        r_idx   <= '0;
                        r_cmp_v <= 1'b0;
                        r_len   <= a_len;
                        r_n     <= (a_len >= LW'(PACKET_BYTES)) ? RES_BITS'(PACKET_BYTES)
                                                                : RES_BITS'(a_len);
                        if (r_a_ctl.skip) begin
                            r_pre_status <= ST_OVERFLOW;
                            r_state      <= S_DONE;
                        end else if (a_len < LW'(MIN_LENGTH)) begin
                            r_pre_status <= ST_SHORT;
                            r_state      <= S_DONE;
                        end else begin
                            r_pre_status <= ST_NONE;
                            r_state      <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx < r_n) begin
                        r_idx   <= r_idx + RES_BITS'(1);
                        r_cmp_v <= 1'b1;
                    end else begin
                        r_cmp_v <= 1'b0;
                    end
                    if (cmp_hit) begin
                        r_have     <= 1'b1;
                        r_best     <= rd_start;
                        r_best_len <= rd_len;
                    end
                    if (r_idx >= r_n && !r_cmp_v) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_v || !i_stall) begin
                        r_state <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_v || !i_stall)) begin
            if (r_have) begin
                r_out_status <= (conf > CONF_BITS'(r_min_packets)) ? ST_FOUND : ST_FEW;
                r_out_pos    <= r_best;
                r_out_conf   <= conf;
            end else begin
                r_out_status <= r_pre_status;
                r_out_pos    <= '0;
                r_out_conf   <= '0;
            end
        end
    end

    assign o_valid         = r_out_v;
    assign o_status        = r_out_status;
    assign o_position      = r_out_pos;
    assign o_confirmations = r_out_conf;

endmodule

// ===== hw/rtl/ts_sync_search_unit.sv =====
// A byte passes through the queue and the stage A register before it is written to the run tables.
// One byte per cycle within a buffer while the back end is in its run state, set by the table read-modify-write.
// After the last byte the back end scans min(length, PACKET_BYTES) table entries and then reports;
// a short or overflowed buffer skips the scan. Input stalls once the 4-item queue fills.
// Reset (synchronous, active low) clears control state; min_packets returns to 3.
// The run tables need no clearing: every entry the scan reads is rewritten earlier in the same buffer.
// ----------------------------------------------------------------------------
// ts_sync_search_unit
// Transport stream sync acquisition over a byte buffer, one byte per item.
// ----------------------------------------------------------------------------
module ts_sync_search_unit #(
    parameter int PACKET_BYTES  = 188,
    parameter int POSITION_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [7:0]                        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ts_ss_pkg::STATUS_BITS-1:0] o_status,
    output logic [POSITION_BITS-1:0]          o_position,
    output logic [ts_ss_pkg::CONF_BITS-1:0]   o_confirmations
);
    import ts_ss_pkg::*;

    localparam int QW = $bits(t_item_ctl) + POSITION_BITS;

    logic                     push;
    logic                     full;
    logic                     pop;
    logic                     empty;
    t_item_ctl                f_ctl;
    logic [POSITION_BITS-1:0] f_pos;
    t_item_ctl                b_ctl;
    logic [POSITION_BITS-1:0] b_pos;
    logic [QW-1:0]            q_out;

    ts_ss_front #(
        .PACKET_BYTES  (PACKET_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_full      (full),
        .o_push      (push),
        .o_ctl       (f_ctl),
        .o_pos       (f_pos)
    );

    ts_ss_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_pos}),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    assign b_ctl = q_out[QW-1:POSITION_BITS];
    assign b_pos = q_out[POSITION_BITS-1:0];

    ts_ss_back #(
        .PACKET_BYTES  (PACKET_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_empty         (empty),
        .i_ctl           (b_ctl),
        .i_pos           (b_pos),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_position      (o_position),
        .o_confirmations (o_confirmations)
    );

endmodule

// ===== verif/ts_sync_search_unit_test.sv =====
// ----------------------------------------------------------------------------
// ts_sync_search_unit_test
// Self-checking bench for the transport stream sync search unit. Byte buffers
// (short, noisy, well-formed streams with broken or fake syncs) are pushed
// through the byte channel. A local model of the run tables predicts each
// buffer report, and every report is compared field by field as it leaves the
// block. Sender gaps and receiver stalls vary per phase.
// ----------------------------------------------------------------------------
module ts_sync_search_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ts_ss_pkg::*;

    // narrow position counter to run the block below its default width
    localparam int          PKT_BYTES     = 188;
    localparam int          POS_BITS      = 12;
    localparam int unsigned POS_LIMIT     = 1 << POS_BITS;
    localparam int unsigned PHASE_BYTES   = 110;
    localparam int unsigned PHASE_BUFFERS = 4;
    localparam int unsigned MAX_SHOWN     = 10;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [POS_BITS-1:0]    position;
        logic [CONF_BITS-1:0]   confirmations;
    } t_sync_report;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [7:0]             i_cfg_data  = 8'd0;
    logic                   i_valid     = 1'b0;
    logic [7:0]             i_data_byte = 8'd0;
    logic                   i_last      = 1'b0;
    logic                   i_stall     = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [STATUS_BITS-1:0] o_status;
    logic [POS_BITS-1:0]    o_position;
    logic [CONF_BITS-1:0]   o_confirmations;

    // sync search model state
    int unsigned  fill_count;
    int unsigned  lane;
    int unsigned  lane_start [PKT_BYTES];
    int unsigned  lane_run   [PKT_BYTES];
    bit           overflowed;
    logic [7:0]   min_packets_model = MIN_PACKETS_RST;

    t_sync_report pending_reports [$];
    logic [7:0]   stream_buf [$];

    int unsigned  sender_gap_pct     = 0;
    int unsigned  receiver_stall_pct = 0;
    int unsigned  fake_sync_pct      = 0;
    int unsigned  bytes_sent         = 0;
    int unsigned  buffers_sent       = 0;
    int unsigned  reports_checked    = 0;
    int unsigned  fault_count        = 0;
    int unsigned  status_tally [1 << STATUS_BITS];

    ts_sync_search_unit #(
        .PACKET_BYTES  (PKT_BYTES),
        .POSITION_BITS (POS_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_position      (o_position),
        .o_confirmations (o_confirmations)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
    end

    function automatic void log_fault(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
        fault_count++;
        if (fault_count <= MAX_SHOWN) begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // Track the trailing sync run per residue; on the last byte pick the
    // earliest run start that still leaves room for a whole packet.
    function automatic void predict_byte(input logic [7:0] value, input logic final_byte);
        t_sync_report rpt;
        int unsigned  span;
        int unsigned  best_start;
        int unsigned  best_run;
        int unsigned  conf;
        bit           have;
        if (!overflowed) begin
            if (fill_count >= POS_LIMIT) begin
                overflowed = 1'b1;
            end else begin
                if (value == SYNC_BYTE) begin
                    if (fill_count < PKT_BYTES || lane_run[lane] == 0) begin
                        lane_start[lane] = fill_count;
                        lane_run[lane]   = 1;
                    end else if (lane_run[lane] < RUN_MAX) begin
                        lane_run[lane]++;
                    end
                end else begin
                    lane_run[lane] = 0;
                end
                fill_count++;
                lane = (lane + 1 == PKT_BYTES) ? 0 : lane + 1;
            end
        end
        if (!final_byte) return;

        rpt        = '0;
        rpt.status = ST_NONE;
        if (overflowed) begin
            rpt.status = ST_OVERFLOW;
        end else if (fill_count < MIN_LENGTH) begin
            rpt.status = ST_SHORT;
        end else begin
            span       = (fill_count < PKT_BYTES) ? fill_count : PKT_BYTES;
            have       = 1'b0;
            best_start = 0;
            best_run   = 0;
            for (int unsigned r = 0; r < span; r++) begin
                if (lane_run[r] != 0 && lane_start[r] + PKT_BYTES <= fill_count &&
                    (!have || lane_start[r] < best_start)) begin
                    have       = 1'b1;
                    best_start = lane_start[r];
                    best_run   = lane_run[r];
                end
            end
            if (have) begin
                conf              = best_run - 1;
                rpt.position      = best_start[POS_BITS-1:0];
                rpt.confirmations = conf[CONF_BITS-1:0];
                rpt.status        = (conf > min_packets_model) ? ST_FOUND : ST_FEW;
            end
        end
        pending_reports.push_back(rpt);
        status_tally[rpt.status]++;
        fill_count = 0;
        lane       = 0;
        overflowed = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_sync_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_reports.size() == 0) begin
                log_fault("report with none pending", 32'd0, 32'(o_status));
            end else begin
                want = pending_reports.pop_front();
                if (o_status !== want.status)
                    log_fault("status", 32'(want.status), 32'(o_status));
                if (o_position !== want.position)
                    log_fault("position", 32'(want.position), 32'(o_position));
                if (o_confirmations !== want.confirmations)
                    log_fault("confirmations", 32'(want.confirmations), 32'(o_confirmations));
                reports_checked++;
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic final_byte);
        while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= value;
        i_last      <= final_byte;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        predict_byte(value, final_byte);
        bytes_sent++;
        if (final_byte) buffers_sent++;
    endtask

    task automatic send_buffer();
        for (int unsigned i = 0; i < stream_buf.size(); i++) begin
            send_byte(stream_buf[i], i == stream_buf.size() - 1);
        end
    endtask

    // hold the byte channel until every report has been seen
    task automatic await_reports();
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        min_packets_model = value;
    endtask

    function automatic logic [7:0] noise_byte();
        if (fake_sync_pct != 0 && $urandom_range(99) < fake_sync_pct) return SYNC_BYTE;
        return 8'($urandom_range(255));
    endfunction

    function automatic void build_noise(input int unsigned len);
        stream_buf.delete();
        repeat (len) stream_buf.push_back(noise_byte());
    endfunction

    // lead noise, whole packets, then a partial packet of tail bytes
    function automatic void build_stream(input int unsigned lead, input int unsigned packets,
                                         input int unsigned tail, input int unsigned break_pct);
        stream_buf.delete();
        repeat (lead) stream_buf.push_back(noise_byte());
        repeat (packets) begin
            stream_buf.push_back(($urandom_range(99) < break_pct) ? noise_byte() : SYNC_BYTE);
            repeat (PKT_BYTES - 1) stream_buf.push_back(noise_byte());
        end
        if (tail != 0) begin
            stream_buf.push_back(($urandom_range(99) < break_pct) ? noise_byte() : SYNC_BYTE);
            repeat (tail - 1) stream_buf.push_back(noise_byte());
        end
    endfunction

    task automatic test_short_buffers();
        stream_buf = '{SYNC_BYTE};
        send_buffer();
        stream_buf = '{8'h00, 8'hFF};
        send_buffer();
        stream_buf = '{SYNC_BYTE, SYNC_BYTE, SYNC_BYTE};
        send_buffer();
        // long enough to search, too short for a packet
        stream_buf = '{SYNC_BYTE, 8'hFF, 8'h00, SYNC_BYTE};
        send_buffer();
    endtask

    task automatic test_single_packet();
        fake_sync_pct = 0;
        build_stream(0, 1, 0, 0);
        send_buffer();
        // one byte short of a whole packet
        build_stream(0, 1, 0, 0);
        void'(stream_buf.pop_back());
        send_buffer();
    endtask

    task automatic test_backtracking();
        fake_sync_pct = 0;
        // earlier candidate holds for one stride then breaks
        build_stream(20, 2, 1, 0);
        stream_buf[5]   = SYNC_BYTE;
        stream_buf[193] = SYNC_BYTE;
        stream_buf[381] = 8'h00;
        send_buffer();
    endtask

    task automatic test_threshold();
        logic [7:0] levels [2] = '{8'd0, 8'd255};
        fake_sync_pct = 0;
        foreach (levels[i]) begin
            await_reports();
            set_threshold(levels[i]);
            build_stream(0, 1, 1, 0);
            send_buffer();
        end
    endtask

    task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                       input logic [7:0] threshold);
        int unsigned first_bytes;
        int unsigned first_buffers;
        int unsigned kind;
        await_reports();
        set_threshold(threshold);
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        first_bytes        = bytes_sent;
        first_buffers      = buffers_sent;
        while (bytes_sent - first_bytes < PHASE_BYTES ||
               buffers_sent - first_buffers < PHASE_BUFFERS) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
                fake_sync_pct = $urandom_range(1) ? 50 : 0;
                build_noise($urandom_range(1, 12));
            end else if (kind < 85) begin
                fake_sync_pct = $urandom_range(2) * 20;
                build_noise($urandom_range(13, 60));
            end else begin
                fake_sync_pct = ($urandom_range(3) == 0) ? 5 : 0;
                build_stream($urandom_range(6), 1, $urandom_range(8),
                             ($urandom_range(3) == 0) ? 25 : 0);
            end
            send_buffer();
            if ($urandom_range(99) < 5) await_reports();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_buffers();
        test_single_packet();
        test_backtracking();
        test_threshold();

        test_random_traffic(0, 0, 8'd1);
        test_random_traffic(62, 0, 8'd0);
        test_random_traffic(0, 62, 8'($urandom_range(4)));
        test_random_traffic(33, 33, 8'd2);

        sender_gap_pct = 0;
        await_reports();
        repeat (200) @(posedge i_clk);
        if (pending_reports.size() != 0)
            log_fault("reports still outstanding", 32'd0, pending_reports.size());

        $display("Sent %0d buffers (%0d bytes), checked %0d reports over min_packets 0..255",
                 buffers_sent, bytes_sent, reports_checked);
        $display("found %0d, too few %0d, none %0d, short %0d, overflow %0d; mismatches %0d",
                 status_tally[ST_FOUND], status_tally[ST_FEW], status_tally[ST_NONE],
                 status_tally[ST_SHORT], status_tally[ST_OVERFLOW], fault_count);
        if (fault_count == 0) begin
            $display("** ts_sync_search_unit: PASSED **");
        end else begin
            $display("** ts_sync_search_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("watchdog expired with %0d reports outstanding", pending_reports.size());
        $display("** ts_sync_search_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ts_ss_pkg.sv
hw/rtl/ts_ss_front.sv
hw/rtl/ts_ss_queue.sv
hw/rtl/ts_ss_back.sv
hw/rtl/ts_sync_search_unit.sv
verif/ts_sync_search_unit_test.sv
